// File: rtl/wcg_pkg.sv
`timescale 1ns / 1ps

package wcg_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF  = 16;

    localparam int INDEX_W = 16;
    localparam int STEP_W  = 16;
    localparam int KIND_W  = 2;
    localparam int COEF_W  = 16;

    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;

    // gain-corrected 1.0 in Q30
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Q30 window constants
    localparam longint K_HALF = 64'sd536870912;
    localparam longint K_054  = 64'sd579820585;
    localparam longint K_046  = 64'sd493921239;
    localparam longint K_042  = 64'sd450971566;
    localparam longint K_008  = 64'sd85899346;

    localparam logic [KIND_W-1:0] KIND_HANN     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HAMMING  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLACKMAN = 2'd2;

    localparam logic REG_WINDOW_KIND = 1'b0;
    localparam logic REG_PHASE_STEP  = 1'b1;

    localparam logic [COEF_W-1:0] COEF_MAX = 16'd32768;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } lane_t;

    typedef struct packed {
        lane_t l1;
        lane_t l2;
    } cell_data_t;

    // arctangent of 2^-i in units of 2^-32 turns
    function automatic logic signed [Z_W-1:0] atan_turns(input int i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                0:  v = 33'sd536870912;
                1:  v = 33'sd316933406;
                2:  v = 33'sd167458907;
                3:  v = 33'sd85004756;
                4:  v = 33'sd42667331;
                5:  v = 33'sd21354465;
                6:  v = 33'sd10679838;
                7:  v = 33'sd5340245;
                8:  v = 33'sd2670163;
                9:  v = 33'sd1335087;
                10: v = 33'sd667544;
                11: v = 33'sd333772;
                12: v = 33'sd166886;
                13: v = 33'sd83443;
                14: v = 33'sd41722;
                15: v = 33'sd20861;
                16: v = 33'sd10430;
                17: v = 33'sd5215;
                18: v = 33'sd2608;
                19: v = 33'sd1304;
                20: v = 33'sd652;
                21: v = 33'sd326;
                22: v = 33'sd163;
                23: v = 33'sd81;
                24: v = 33'sd41;
                25: v = 33'sd20;
                26: v = 33'sd10;
                27: v = 33'sd5;
                28: v = 33'sd3;
                29: v = 33'sd1;
                default: v = 33'sd0;
            endcase
            return v;
        end
    endfunction

    // round a positive Q30 constant to Qf
    function automatic longint round_q30(input longint k, input int f);
        begin
            return (k + (64'sd1 <<< (29 - f))) >>> (30 - f);
        end
    endfunction

endpackage

// File: rtl/window_coefficient_generator_top.sv
`timescale 1ns / 1ps

// Window coefficient generator: Hann, Hamming or three-term Blackman.
// s_axis carries a sample index, m_axis returns one Q1.15 coefficient
// (32768 = 1.0) per index, in order. cfg writes register 0 (window kind)
// or register 1 (phase step, 65536/N turns per sample); cfg_ready is
// always high, and writes are meant for times when no item is in flight.
// From an s_axis transfer to m_axis_tvalid, the index-times-step product
// is registered, then passes the row of CORDIC cells (one rotation per
// cell, cosine and double-angle cosine side by side), then registers that
// sign-fold and round, weight, and sum and clamp, then one output register.
// Throughput is one item per cycle while m_axis_tready stays high.
// When the receiver stalls, the output register holds its result and a
// skid register takes the next one; only then does s_axis_tready drop
// and the whole pipeline freeze until the skid register drains.
// Reset clears all valid bits and sets kind Hann and phase step 64.
module window_coefficient_generator_top #(
    parameter int PHASE_BITS = wcg_pkg::PHASE_BITS_DEF,
    parameter int COEF_BITS  = wcg_pkg::COEF_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] coefficient
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int N = wcg_pkg::CORDIC_STEPS;
    localparam logic [63:0] LOW_MASK = (64'd1 << (32 - PHASE_BITS)) - 64'd1;
    localparam logic [31:0] ANG_MASK = ~LOW_MASK[31:0];

    logic [wcg_pkg::KIND_W-1:0] kind_reg;
    logic [wcg_pkg::STEP_W-1:0] step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= wcg_pkg::KIND_HANN;
            step_reg <= 16'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wcg_pkg::REG_WINDOW_KIND: kind_reg <= cfg_data[wcg_pkg::KIND_W-1:0];
                wcg_pkg::REG_PHASE_STEP:  step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the skid register is empty
    logic skid_valid_reg;
    logic en;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // phase = index * step mod one turn
    logic [31:0] prod;
    logic [15:0] phase_reg;
    logic        p_valid_reg;

    assign prod = s_axis_tdata * step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phase_reg <= prod[15:0];
        end
    end

    // fold quadrants 1 and 2 by half a turn, negate the result later
    function automatic wcg_pkg::lane_t lane_init(input logic [31:0] ang);
        wcg_pkg::lane_t l;
        logic [31:0]    a;
        begin
            l.neg = ang[31] ^ ang[30];
            a = l.neg ? {~ang[31], ang[30:0]} : ang;
            l.z = {a[31], a};
            l.x = wcg_pkg::CORDIC_X0;
            l.y = '0;
            return l;
        end
    endfunction

    logic [31:0]         ang1;
    logic [31:0]         ang2;
    wcg_pkg::cell_data_t head;

    always_comb
    begin
        ang1 = {phase_reg, 16'd0} & ANG_MASK;
        ang2 = {ang1[30:0], 1'b0};
        head.l1 = lane_init(ang1);
        head.l2 = lane_init(ang2);
    end

    logic                cv [N+1];
    wcg_pkg::cell_data_t cd [N+1];

    assign cv[0] = p_valid_reg;
    assign cd[0] = head;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        wcg_cordic_cell #(
            .STEP(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .valid_in (cv[i]),
            .data_in  (cd[i]),
            .valid_out(cv[i+1]),
            .data_out (cd[i+1])
        );
    end

    logic        r_valid;
    logic [15:0] r_coef;

    wcg_combine #(
        .COEF_BITS(COEF_BITS)
    ) u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .window_kind(kind_reg),
        .valid_in   (cv[N]),
        .data_in    (cd[N]),
        .valid_out  (r_valid),
        .coefficient(r_coef)
    );

    // output register plus skid register
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [15:0] skid_data_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (r_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (r_valid)
        begin
            if (out_free)
            begin
                out_data_reg <= r_coef;
            end
            else
            begin
                skid_data_reg <= r_coef;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: rtl/wcg_cordic_cell.sv
`timescale 1ns / 1ps

module wcg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  wcg_pkg::cell_data_t data_in,
    output logic                valid_out,
    output wcg_pkg::cell_data_t data_out
);

    localparam logic signed [wcg_pkg::Z_W-1:0] ATAN = wcg_pkg::atan_turns(STEP);

    logic                valid_reg;
    wcg_pkg::cell_data_t data_reg;
    wcg_pkg::cell_data_t data_next;

    function automatic wcg_pkg::lane_t rotate(input wcg_pkg::lane_t l);
        wcg_pkg::lane_t         r;
        logic signed [wcg_pkg::XY_W-1:0] xs;
        logic signed [wcg_pkg::XY_W-1:0] ys;
        begin
            xs = l.x >>> STEP;
            ys = l.y >>> STEP;
            r.neg = l.neg;
            if (!l.z[wcg_pkg::Z_W-1])
            begin
                r.x = l.x - ys;
                r.y = l.y + xs;
                r.z = l.z - ATAN;
            end
            else
            begin
                r.x = l.x + ys;
                r.y = l.y - xs;
                r.z = l.z + ATAN;
            end
            return r;
        end
    endfunction

    always_comb
    begin
        data_next.l1 = rotate(data_in.l1);
        data_next.l2 = rotate(data_in.l2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// File: rtl/wcg_combine.sv
`timescale 1ns / 1ps

module wcg_combine #(
    parameter int COEF_BITS = wcg_pkg::COEF_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [wcg_pkg::KIND_W-1:0]        window_kind,
    input  logic                              valid_in,
    input  wcg_pkg::cell_data_t               data_in,
    output logic                              valid_out,
    output logic [wcg_pkg::COEF_W-1:0]        coefficient
);

    localparam int F  = COEF_BITS - 2;
    localparam int CW = F + 2;
    localparam int PW = 2 * CW;
    localparam int SW = PW + 1;
    localparam int XS = 30 - F;
    localparam int RS = 2 * F - 15;

    localparam logic signed [wcg_pkg::XY_W-1:0] X_HALF =
        wcg_pkg::XY_W'(64'sd1 <<< (XS - 1));
    localparam logic signed [SW-1:0] W_HALF = SW'(64'sd1 <<< (RS - 1));

    localparam logic signed [CW-1:0] A_HALF = CW'(wcg_pkg::round_q30(wcg_pkg::K_HALF, F));
    localparam logic signed [CW-1:0] A_054  = CW'(wcg_pkg::round_q30(wcg_pkg::K_054, F));
    localparam logic signed [CW-1:0] A_046  = CW'(wcg_pkg::round_q30(wcg_pkg::K_046, F));
    localparam logic signed [CW-1:0] A_042  = CW'(wcg_pkg::round_q30(wcg_pkg::K_042, F));
    localparam logic signed [CW-1:0] A_008  = CW'(wcg_pkg::round_q30(wcg_pkg::K_008, F));

    logic signed [CW-1:0] a0;
    logic signed [CW-1:0] a1;
    logic signed [CW-1:0] a2;
    logic                 kind_ok;

    always_comb
    begin
        a0 = '0;
        a1 = '0;
        a2 = '0;
        kind_ok = 1'b1;
        case (window_kind)
            wcg_pkg::KIND_HANN:
            begin
                a0 = A_HALF;
                a1 = A_HALF;
            end
            wcg_pkg::KIND_HAMMING:
            begin
                a0 = A_054;
                a1 = A_046;
            end
            wcg_pkg::KIND_BLACKMAN:
            begin
                a0 = A_042;
                a1 = A_HALF;
                a2 = A_008;
            end
            default:
            begin
                kind_ok = 1'b0;
            end
        endcase
    end

    // stage 1: sign fold and round both cosines to QF
    logic signed [wcg_pkg::XY_W-1:0] x1_s;
    logic signed [wcg_pkg::XY_W-1:0] x2_s;
    logic signed [wcg_pkg::XY_W-1:0] x1_sh;
    logic signed [wcg_pkg::XY_W-1:0] x2_sh;
    logic signed [CW-1:0]            c1_next;
    logic signed [CW-1:0]            c2_next;
    logic signed [CW-1:0]            c1_reg;
    logic signed [CW-1:0]            c2_reg;
    logic                            v1_reg;

    always_comb
    begin
        x1_s = data_in.l1.neg ? -data_in.l1.x : data_in.l1.x;
        x2_s = data_in.l2.neg ? -data_in.l2.x : data_in.l2.x;
        x1_sh = (x1_s + X_HALF) >>> XS;
        x2_sh = (x2_s + X_HALF) >>> XS;
        c1_next = x1_sh[CW-1:0];
        c2_next = x2_sh[CW-1:0];
    end

    // stage 2: weight the cosine terms
    logic signed [PW-1:0] t1_next;
    logic signed [PW-1:0] t2_next;
    logic signed [PW-1:0] t1_reg;
    logic signed [PW-1:0] t2_reg;
    logic                 v2_reg;

    assign t1_next = a1 * c1_reg;
    assign t2_next = a2 * c2_reg;

    // stage 3: sum, round to Q15, clamp
    logic signed [SW-1:0]         w_sum;
    logic signed [SW-1:0]         w_rnd;
    logic [wcg_pkg::COEF_W-1:0]   coef_next;
    logic [wcg_pkg::COEF_W-1:0]   coef_reg;
    logic                         v3_reg;

    always_comb
    begin
        w_sum = (SW'(a0) <<< F) - SW'(t1_reg) + SW'(t2_reg);
        w_rnd = (w_sum + W_HALF) >>> RS;
        if (!kind_ok || w_rnd[SW-1])
        begin
            coef_next = '0;
        end
        else if (w_rnd > SW'(wcg_pkg::COEF_MAX))
        begin
            coef_next = wcg_pkg::COEF_MAX;
        end
        else
        begin
            coef_next = w_rnd[wcg_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c1_next;
            c2_reg   <= c2_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            coef_reg <= coef_next;
        end
    end

    assign valid_out   = v3_reg;
    assign coefficient = coef_reg;

endmodule
